// ===== rtl/cmos_clock_time_decoder_macros.svh =====
// Assertion macros for the RTC time decoder.
// Included by the decoder top level; needs clk and rst_n in the including scope.
`ifndef CMOS_CLOCK_TIME_DECODER_MACROS_SVH
`define CMOS_CLOCK_TIME_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CCTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cctd_pkg.sv =====
// Types, constants and helper functions for the RTC time decoder.
// No dependencies; used by cmos_clock_time_decoder.
`default_nettype none

package cctd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BINARY_MODE     = 2'd0,
    CFG_HOUR24_MODE     = 2'd1,
    CFG_DEFAULT_CENTURY = 2'd2
  } cfg_idx_t;

  localparam logic [6:0]  MAX_BYTE_VAL     = 7'd99;
  localparam logic [6:0]  DEFAULT_CENTURY  = 7'd20;
  localparam logic [13:0] YEAR_BASE        = 14'd1900;
  localparam logic [13:0] EPOCH_YEAR       = 14'd1970;
  localparam logic [22:0] DAYS_PER_YEAR    = 23'd365;
  localparam logic [38:0] SECONDS_PER_DAY  = 39'd86400;

  typedef struct packed {
    logic [6:0] val;
    logic       err;
  } dec_t;

  // Decode one register byte (BCD or binary) and saturate at 99.
  function automatic dec_t dec_byte(input logic [7:0] b, input logic bcd);
    logic [7:0] v;
    dec_t       d;
    d.err = 1'b0;
    if (bcd) begin
      d.err = (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
      v = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    end else begin
      v = b;
    end
    if (v > {1'b0, MAX_BYTE_VAL}) begin
      d.err = 1'b1;
      d.val = MAX_BYTE_VAL;
    end else begin
      d.val = v[6:0];
    end
    return d;
  endfunction

  // Days in the months before the given 0-based month, non-leap year.
  function automatic logic [8:0] cum_days(input logic [3:0] midx);
    logic [8:0] r;
    unique case (midx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Stage 1: decoded bytes
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [6:0] hr;
    logic [6:0] day;
    logic [6:0] mon;
    logic [7:0] wd;
    logic [6:0] yr;
    logic [6:0] cen;
    logic       pm;
    logic       h12;
    logic       err;
  } s1_t;

  // Stage 2: checked, clamped, full year
  typedef struct packed {
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [6:0]  hr;
    logic [6:0]  day;
    logic [3:0]  monc;
    logic [4:0]  dayc;
    logic [2:0]  wdc;
    logic [13:0] full;
    logic        leap;
    logic [4:0]  hs;
    logic [5:0]  ms;
    logic [5:0]  ss;
    logic        err;
  } s2_t;

  // Stage 3: day of year, year offsets, time of day
  typedef struct packed {
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [6:0]  hr;
    logic [6:0]  day;
    logic [3:0]  mon_idx;
    logic [13:0] ysince;
    logic [2:0]  wd_idx;
    logic [8:0]  yday;
    logic [13:0] yrs70;
    logic [16:0] tod;
    logic        err;
  } s3_t;

  // Stage 4: day count since epoch
  typedef struct packed {
    logic [6:0]  sec;
    logic [6:0]  min;
    logic [6:0]  hr;
    logic [6:0]  day;
    logic [3:0]  mon_idx;
    logic [13:0] ysince;
    logic [2:0]  wd_idx;
    logic [8:0]  yday;
    logic [22:0] days;
    logic [16:0] tod;
    logic        err;
  } s4_t;

endpackage

`default_nettype wire

// ===== rtl/cmos_clock_time_decoder.sv =====
// Channel  | Ports                              | Handshake
// request  | in_raw_* (8 x 8 bit)               | start, accepted when start && !busy
// result   | out_* fields, out_range_error      | out_valid strobe, one cycle, no stall
// config   | cfg_we, cfg_index, cfg_wdata       | written on any edge with cfg_we high, outside reset
//
// Five-stage pipeline: decode, check/clamp/year, day of year, day count, epoch.
// One request per cycle; each result is registered in every stage before it reaches the outputs.
// busy stays low: the pipeline never stalls since the receiver cannot.
// Synchronous active-low reset clears stage valid bits and sets the config registers to binary, 24-hour, century 20.
// Depends on cctd_pkg and cmos_clock_time_decoder_macros.svh.
`default_nettype none

`include "cmos_clock_time_decoder_macros.svh"

module cmos_clock_time_decoder (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [7:0]         in_raw_second,
  input  wire  [7:0]         in_raw_minute,
  input  wire  [7:0]         in_raw_hour,
  input  wire  [7:0]         in_raw_day,
  input  wire  [7:0]         in_raw_month,
  input  wire  [7:0]         in_raw_weekday,
  input  wire  [7:0]         in_raw_year,
  input  wire  [7:0]         in_raw_century,
  output logic               out_valid,
  output logic [6:0]         out_second,
  output logic [6:0]         out_minute,
  output logic [6:0]         out_hour,
  output logic [6:0]         out_month_day,
  output logic [3:0]         out_month_index,
  output logic signed [13:0] out_years_since_1900,
  output logic [2:0]         out_week_day,
  output logic [8:0]         out_year_day,
  output logic signed [38:0] out_epoch_seconds,
  output logic               out_range_error,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [6:0]         cfg_wdata
);

  logic       binary_mode_r;
  logic       hour24_mode_r;
  logic [6:0] default_century_r;

  logic [4:0] valid_r;

  cctd_pkg::s1_t s1_r, s1_nxt;
  cctd_pkg::s2_t s2_r, s2_nxt;
  cctd_pkg::s3_t s3_r, s3_nxt;
  cctd_pkg::s4_t s4_r, s4_nxt;

  logic [6:0]  sec_r, min_r, hr_r, mday_r;
  logic [3:0]  mon_idx_r;
  logic [13:0] ysince_r;
  logic [2:0]  wd_idx_r;
  logic [8:0]  yday_r;
  logic [38:0] epoch_r, epoch_nxt;
  logic        err_r;

  logic in_accept;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r     <= 1'b1;
      hour24_mode_r     <= 1'b1;
      default_century_r <= cctd_pkg::DEFAULT_CENTURY;
    end else if (cfg_we) begin
      unique case (cctd_pkg::cfg_idx_t'(cfg_index))
        cctd_pkg::CFG_BINARY_MODE:     binary_mode_r     <= cfg_wdata[0];
        cctd_pkg::CFG_HOUR24_MODE:     hour24_mode_r     <= cfg_wdata[0];
        cctd_pkg::CFG_DEFAULT_CENTURY: default_century_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: byte decode
  always_comb begin
    cctd_pkg::dec_t d_sec, d_min, d_hr, d_day, d_mon, d_yr, d_cen;
    logic           bcd;
    logic           h12;
    logic [7:0]     hraw;
    bcd   = !binary_mode_r;
    h12   = !hour24_mode_r;
    // strip the PM flag before decoding
    hraw  = h12 ? {1'b0, in_raw_hour[6:0]} : in_raw_hour;
    d_sec = cctd_pkg::dec_byte(in_raw_second, bcd);
    d_min = cctd_pkg::dec_byte(in_raw_minute, bcd);
    d_hr  = cctd_pkg::dec_byte(hraw, bcd);
    d_day = cctd_pkg::dec_byte(in_raw_day, bcd);
    d_mon = cctd_pkg::dec_byte(in_raw_month, bcd);
    d_yr  = cctd_pkg::dec_byte(in_raw_year, bcd);
    if (in_raw_century != 8'd0) begin
      d_cen = cctd_pkg::dec_byte(in_raw_century, bcd);
    end else if (default_century_r > cctd_pkg::MAX_BYTE_VAL) begin
      d_cen.val = cctd_pkg::MAX_BYTE_VAL;
      d_cen.err = 1'b1;
    end else begin
      d_cen.val = default_century_r;
      d_cen.err = 1'b0;
    end
    s1_nxt.sec = d_sec.val;
    s1_nxt.min = d_min.val;
    s1_nxt.hr  = d_hr.val;
    s1_nxt.day = d_day.val;
    s1_nxt.mon = d_mon.val;
    s1_nxt.wd  = in_raw_weekday;
    s1_nxt.yr  = d_yr.val;
    s1_nxt.cen = d_cen.val;
    s1_nxt.pm  = h12 && in_raw_hour[7];
    s1_nxt.h12 = h12;
    s1_nxt.err = d_sec.err | d_min.err | d_hr.err | d_day.err | d_mon.err
               | d_yr.err | d_cen.err;
  end

  // Stage 2: range checks, clamps, PM conversion, full year
  always_comb begin
    logic       e;
    logic [6:0] hsum;
    logic [6:0] hconv;
    e = s1_r.err;
    if (s1_r.sec > 7'd59) e = 1'b1;
    if (s1_r.min > 7'd59) e = 1'b1;
    if (s1_r.h12) begin
      if (s1_r.hr < 7'd1 || s1_r.hr > 7'd12) e = 1'b1;
    end else if (s1_r.hr > 7'd23) begin
      e = 1'b1;
    end
    // (hr + 12) mod 24, hr + 12 stays below 112
    hsum = s1_r.hr + 7'd12;
    priority if (hsum >= 7'd96) hconv = hsum - 7'd96;
    else if (hsum >= 7'd72)     hconv = hsum - 7'd72;
    else if (hsum >= 7'd48)     hconv = hsum - 7'd48;
    else if (hsum >= 7'd24)     hconv = hsum - 7'd24;
    else                        hconv = hsum;
    s2_nxt.hr = s1_r.pm ? hconv : s1_r.hr;

    if (s1_r.day == 7'd0) begin
      s2_nxt.dayc = 5'd1;
      e = 1'b1;
    end else if (s1_r.day > 7'd31) begin
      s2_nxt.dayc = 5'd31;
      e = 1'b1;
    end else begin
      s2_nxt.dayc = s1_r.day[4:0];
    end
    if (s1_r.mon == 7'd0) begin
      s2_nxt.monc = 4'd1;
      e = 1'b1;
    end else if (s1_r.mon > 7'd12) begin
      s2_nxt.monc = 4'd12;
      e = 1'b1;
    end else begin
      s2_nxt.monc = s1_r.mon[3:0];
    end
    if (s1_r.wd == 8'd0) begin
      s2_nxt.wdc = 3'd1;
      e = 1'b1;
    end else if (s1_r.wd > 8'd7) begin
      s2_nxt.wdc = 3'd7;
      e = 1'b1;
    end else begin
      s2_nxt.wdc = s1_r.wd[2:0];
    end

    s2_nxt.sec  = s1_r.sec;
    s2_nxt.min  = s1_r.min;
    s2_nxt.day  = s1_r.day;
    s2_nxt.full = {7'd0, s1_r.yr} + {7'd0, s1_r.cen} * 14'd100;
    // century year is leap only when the century is a multiple of four
    s2_nxt.leap = (s1_r.yr[1:0] == 2'b00)
               && ((s1_r.yr != 7'd0) || (s1_r.cen[1:0] == 2'b00));
    s2_nxt.hs   = (s2_nxt.hr > 7'd23) ? 5'd23 : s2_nxt.hr[4:0];
    s2_nxt.ms   = (s1_r.min > 7'd59) ? 6'd59 : s1_r.min[5:0];
    s2_nxt.ss   = (s1_r.sec > 7'd59) ? 6'd59 : s1_r.sec[5:0];
    s2_nxt.err  = e;
  end

  // Stage 3: day of year, year offsets, seconds into the day
  always_comb begin
    logic [3:0] midx;
    logic [8:0] leap_add;
    midx     = s2_r.monc - 4'd1;
    leap_add = {8'd0, (s2_r.monc >= 4'd3) && s2_r.leap};
    s3_nxt.sec     = s2_r.sec;
    s3_nxt.min     = s2_r.min;
    s3_nxt.hr      = s2_r.hr;
    s3_nxt.day     = s2_r.day;
    s3_nxt.mon_idx = midx;
    s3_nxt.wd_idx  = s2_r.wdc - 3'd1;
    s3_nxt.yday    = cctd_pkg::cum_days(midx) + {4'd0, s2_r.dayc} - 9'd1 + leap_add;
    s3_nxt.ysince  = s2_r.full - cctd_pkg::YEAR_BASE;
    s3_nxt.yrs70   = s2_r.full - cctd_pkg::EPOCH_YEAR;
    s3_nxt.tod     = {12'd0, s2_r.hs} * 17'd3600 + {11'd0, s2_r.ms} * 17'd60
                   + {11'd0, s2_r.ss};
    s3_nxt.err     = s2_r.err;
  end

  // Stage 4: days since epoch, 365-day years (modular arithmetic keeps the sign)
  always_comb begin
    logic [22:0] yrs_x;
    yrs_x = {{9{s3_r.yrs70[13]}}, s3_r.yrs70};
    s4_nxt.sec     = s3_r.sec;
    s4_nxt.min     = s3_r.min;
    s4_nxt.hr      = s3_r.hr;
    s4_nxt.day     = s3_r.day;
    s4_nxt.mon_idx = s3_r.mon_idx;
    s4_nxt.ysince  = s3_r.ysince;
    s4_nxt.wd_idx  = s3_r.wd_idx;
    s4_nxt.yday    = s3_r.yday;
    s4_nxt.days    = yrs_x * cctd_pkg::DAYS_PER_YEAR + {14'd0, s3_r.yday};
    s4_nxt.tod     = s3_r.tod;
    s4_nxt.err     = s3_r.err;
  end

  // Stage 5: epoch seconds
  always_comb begin
    logic [38:0] days_x;
    days_x    = {{16{s4_r.days[22]}}, s4_r.days};
    epoch_nxt = days_x * cctd_pkg::SECONDS_PER_DAY + {22'd0, s4_r.tod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[3:0], in_accept};
    end
  end

  // Payload registers; no reset needed
  always_ff @(posedge clk) begin
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    s3_r      <= s3_nxt;
    s4_r      <= s4_nxt;
    sec_r     <= s4_r.sec;
    min_r     <= s4_r.min;
    hr_r      <= s4_r.hr;
    mday_r    <= s4_r.day;
    mon_idx_r <= s4_r.mon_idx;
    ysince_r  <= s4_r.ysince;
    wd_idx_r  <= s4_r.wd_idx;
    yday_r    <= s4_r.yday;
    epoch_r   <= epoch_nxt;
    err_r     <= s4_r.err;
  end

  assign out_valid            = valid_r[4];
  assign out_second           = sec_r;
  assign out_minute           = min_r;
  assign out_hour             = hr_r;
  assign out_month_day        = mday_r;
  assign out_month_index      = mon_idx_r;
  assign out_years_since_1900 = ysince_r;
  assign out_week_day         = wd_idx_r;
  assign out_year_day         = yday_r;
  assign out_epoch_seconds    = epoch_r;
  assign out_range_error      = err_r;

  `CCTD_ASSERT_IMPL(a_result_latency, out_valid, $past(start, 5), "result without request")
  `CCTD_ASSERT_IMPL(a_clean_ranges, out_valid && !out_range_error,
    out_second <= 7'd59 && out_minute <= 7'd59 && out_hour <= 7'd23
    && out_month_day >= 7'd1 && out_month_day <= 7'd31,
    "field out of range without range_error")
  `CCTD_ASSERT_IMPL(a_index_ranges, out_valid,
    out_month_index <= 4'd11 && out_week_day <= 3'd6 && out_year_day <= 9'd365,
    "clamped index out of range")
  `CCTD_ASSERT_NEXT(a_request_flows, valid_r[3], out_valid, "result lost in last stage")

endmodule

`default_nettype wire

// ===== tb/cmos_clock_time_decoder_test.sv =====
// Self-checking testbench for the RTC snapshot decoder: directed rows, then random snapshots
// across mode settings, each result checked against its typed row values or a local model of the decode.
// Depends on cctd_pkg and the cmos_clock_time_decoder RTL.
module cmos_clock_time_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_LATENCY = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 179;
  localparam int DIRECTED_COUNT = 22;
  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Extreme mode settings for the first random phases; the rest are drawn at random.
  localparam bit FIXED_BINARY [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
  localparam bit FIXED_HOUR24 [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic [6:0] FIXED_CENTURY [4] = '{7'd0, 7'd127, 7'd99, 7'd19};

  // One register snapshot; second sits in the top byte.
  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] weekday;
    logic [7:0] year;
    logic [7:0] century;
  } snap_t;

  typedef struct packed {
    logic [6:0]         second;
    logic [6:0]         minute;
    logic [6:0]         hour;
    logic [6:0]         month_day;
    logic [3:0]         month_index;
    logic signed [13:0] years_1900;
    logic [2:0]         week_day;
    logic [8:0]         year_day;
    logic signed [38:0] epoch;
    logic               range_err;
  } clock_fields_t;

  typedef struct packed {
    logic          binary;
    logic          hour24;
    logic [6:0]    century;
    snap_t         snap;
    logic          typed;
    clock_fields_t want;
  } directed_row_t;

  // Snapshot bytes: second minute hour day month weekday year century.
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    // Binary, 24-hour, default century 20: zero century byte gives 2000
    '{1'b1, 1'b1, 7'd20, 64'h00_00_00_01_01_01_00_00, 1'b1,
      '{7'd0, 7'd0, 7'd0, 7'd1, 4'd0, 14'sd100, 3'd0, 9'd0, 39'sd946080000, 1'b0}},
    // Epoch origin
    '{1'b1, 1'b1, 7'd20, 64'h00_00_00_01_01_01_46_13, 1'b1,
      '{7'd0, 7'd0, 7'd0, 7'd1, 4'd0, 14'sd70, 3'd0, 9'd0, 39'sd0, 1'b0}},
    // All zero: day, month and weekday clamp up
    '{1'b1, 1'b1, 7'd20, 64'h00_00_00_00_00_00_00_00, 1'b1,
      '{7'd0, 7'd0, 7'd0, 7'd0, 4'd0, 14'sd100, 3'd0, 9'd0, 39'sd946080000, 1'b1}},
    // All ones: everything saturates or clamps down
    '{1'b1, 1'b1, 7'd20, 64'hFF_FF_FF_FF_FF_FF_FF_FF, 1'b1,
      '{7'd99, 7'd99, 7'd99, 7'd99, 4'd11, 14'sd8099, 3'd6, 9'd364,
        39'sd253234079999, 1'b1}},
    '{1'b1, 1'b1, 7'd20, 64'h3B_3B_17_1F_0C_07_63_63, 1'b0, '0},
    '{1'b1, 1'b1, 7'd20, 64'h3C_3C_18_20_0D_08_64_64, 1'b0, '0},
    // Leap day, March in a 400-year leap and in a century non-leap, last day of a leap year
    '{1'b1, 1'b1, 7'd20, 64'h00_00_0C_1D_02_04_18_14, 1'b0, '0},
    '{1'b1, 1'b1, 7'd20, 64'h00_00_00_01_03_02_00_14, 1'b0, '0},
    '{1'b1, 1'b1, 7'd20, 64'h00_00_00_01_03_02_00_13, 1'b0, '0},
    '{1'b1, 1'b1, 7'd20, 64'h3B_3B_17_1F_0C_03_18_14, 1'b0, '0},
    // BCD, 12-hour: twelve AM, twelve PM, one PM, hour zero, thirteen PM
    '{1'b0, 1'b0, 7'd20, 64'h00_00_12_01_01_01_00_00, 1'b0, '0},
    '{1'b0, 1'b0, 7'd20, 64'h00_00_92_01_01_01_00_00, 1'b0, '0},
    '{1'b0, 1'b0, 7'd20, 64'h30_45_81_15_06_03_24_20, 1'b0, '0},
    '{1'b0, 1'b0, 7'd20, 64'h00_00_00_01_01_01_00_00, 1'b0, '0},
    '{1'b0, 1'b0, 7'd20, 64'h00_00_93_01_01_01_00_00, 1'b0, '0},
    // Bad BCD nibbles; weekday byte stays binary
    '{1'b0, 1'b0, 7'd20, 64'h5A_A0_0F_F0_1A_01_9F_FA, 1'b0, '0},
    '{1'b0, 1'b0, 7'd20, 64'h00_00_01_01_01_10_00_00, 1'b0, '0},
    // Default century above 99 used, then bypassed by a real century byte
    '{1'b0, 1'b1, 7'd127, 64'h59_59_23_31_12_07_99_00, 1'b0, '0},
    '{1'b0, 1'b1, 7'd127, 64'h00_00_00_01_01_05_99_19, 1'b0, '0},
    // Year zero, twelve AM in binary
    '{1'b1, 1'b0, 7'd0, 64'h00_00_0C_01_01_01_00_00, 1'b1,
      '{7'd0, 7'd0, 7'd12, 7'd1, 4'd0, -14'sd1900, 3'd0, 9'd0, -39'sd62125876800, 1'b0}},
    '{1'b1, 1'b0, 7'd0, 64'h3B_3B_8B_1F_0C_07_63_00, 1'b0, '0},
    '{1'b0, 1'b1, 7'd99, 64'h59_59_23_31_12_07_99_00, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  snap_t                stim = '0;
  logic                 cfg_we = 1'b0;
  cctd_pkg::cfg_idx_t   cfg_index = cctd_pkg::CFG_BINARY_MODE;
  logic [6:0]           cfg_wdata = '0;
  logic                 typed_valid = 1'b0;
  clock_fields_t        typed_want = '0;

  logic               out_valid;
  logic [6:0]         out_second;
  logic [6:0]         out_minute;
  logic [6:0]         out_hour;
  logic [6:0]         out_month_day;
  logic [3:0]         out_month_index;
  logic signed [13:0] out_years_since_1900;
  logic [2:0]         out_week_day;
  logic [8:0]         out_year_day;
  logic signed [38:0] out_epoch_seconds;
  logic               out_range_error;

  // Mirror of the mode registers as the block holds them
  bit         mode_binary = 1'b1;
  bit         mode_hour24 = 1'b1;
  logic [6:0] mode_century = 7'd20;

  clock_fields_t pending_times [$];
  int error_count = 0;
  int idle_cycles = 0;
  int checked_count = 0;
  int flagged_count = 0;
  int setting_count = 1;

  cmos_clock_time_decoder i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_raw_second        (stim.second),
    .in_raw_minute        (stim.minute),
    .in_raw_hour          (stim.hour),
    .in_raw_day           (stim.day),
    .in_raw_month         (stim.month),
    .in_raw_weekday       (stim.weekday),
    .in_raw_year          (stim.year),
    .in_raw_century       (stim.century),
    .out_valid            (out_valid),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_month_day        (out_month_day),
    .out_month_index      (out_month_index),
    .out_years_since_1900 (out_years_since_1900),
    .out_week_day         (out_week_day),
    .out_year_day         (out_year_day),
    .out_epoch_seconds    (out_epoch_seconds),
    .out_range_error      (out_range_error),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned rtc_byte_value(input logic [7:0] b, input bit bcd,
                                                 inout bit bad);
    int unsigned v;
    if (bcd) begin
      if (b[7:4] > 4'd9 || b[3:0] > 4'd9) bad = 1'b1;
      v = b[7:4] * 10 + b[3:0];
    end else begin
      v = b;
    end
    if (v > 99) begin
      bad = 1'b1;
      v = 99;
    end
    return v;
  endfunction

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi, inout bit bad);
    if (v < lo) begin
      bad = 1'b1;
      return lo;
    end
    if (v > hi) begin
      bad = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic clock_fields_t decode_rtc_snapshot(input snap_t s);
    clock_fields_t r;
    bit            bad, bcd, h12, pm, leap;
    logic [7:0]    hbyte;
    int unsigned   sec, mins, hr, day, mon, yr, cen, dayc, monc, wdc, full, yday;
    longint        ysince, days, epoch;
    bad = 1'b0;
    bcd = !mode_binary;
    h12 = !mode_hour24;
    sec = rtc_byte_value(s.second, bcd, bad);
    mins = rtc_byte_value(s.minute, bcd, bad);
    hbyte = s.hour;
    pm = h12 && hbyte[7];
    if (h12) hbyte[7] = 1'b0;
    hr = rtc_byte_value(hbyte, bcd, bad);
    day = rtc_byte_value(s.day, bcd, bad);
    mon = rtc_byte_value(s.month, bcd, bad);
    yr = rtc_byte_value(s.year, bcd, bad);
    if (s.century != 8'd0) begin
      cen = rtc_byte_value(s.century, bcd, bad);
    end else begin
      cen = mode_century;
      if (cen > 99) begin
        bad = 1'b1;
        cen = 99;
      end
    end
    if (sec > 59) bad = 1'b1;
    if (mins > 59) bad = 1'b1;
    if (h12) begin
      if (hr < 1 || hr > 12) bad = 1'b1;
      if (pm) hr = (hr + 12) % 24;
    end else if (hr > 23) begin
      bad = 1'b1;
    end
    dayc = clamp_to(day, 1, 31, bad);
    monc = clamp_to(mon, 1, 12, bad);
    wdc = clamp_to(s.weekday, 1, 7, bad);
    full = yr + cen * 100;
    leap = (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
    yday = dayc - 1;
    for (int m = 1; m < monc; m++) yday += DAYS_IN_MONTH[m - 1];
    if (monc >= 3 && leap) yday += 1;
    ysince = longint'(full) - 1900;
    days = (ysince - 70) * 365 + longint'(yday);
    // Out-of-range time of day counts at its top legal value
    epoch = ((days * 24 + longint'(hr > 23 ? 23 : hr)) * 60
             + longint'(mins > 59 ? 59 : mins)) * 60 + longint'(sec > 59 ? 59 : sec);
    r.second = sec[6:0];
    r.minute = mins[6:0];
    r.hour = hr[6:0];
    r.month_day = day[6:0];
    r.month_index = 4'(monc - 1);
    r.years_1900 = ysince[13:0];
    r.week_day = 3'(wdc - 1);
    r.year_day = yday[8:0];
    r.epoch = epoch[38:0];
    r.range_err = bad;
    return r;
  endfunction

  function automatic string show_fields(input clock_fields_t f);
    return $sformatf("s=%0d m=%0d h=%0d md=%0d mi=%0d y=%0d wd=%0d yd=%0d ep=%0d err=%0d",
                     f.second, f.minute, f.hour, f.month_day, f.month_index, f.years_1900,
                     f.week_day, f.year_day, f.epoch, f.range_err);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // Result checking, request capture, register mirror and watchdog
  always @(posedge clk) begin : monitor
    clock_fields_t got, want;
    if (!rst_n) begin
      mode_binary = 1'b1;
      mode_hour24 = 1'b1;
      mode_century = 7'd20;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (out_valid) begin
        idle_cycles = 0;
        got = '{out_second, out_minute, out_hour, out_month_day, out_month_index,
                out_years_since_1900, out_week_day, out_year_day, out_epoch_seconds,
                out_range_error};
        if (out_range_error) flagged_count++;
        if (pending_times.size() == 0) begin
          flag_error($sformatf("unexpected result %s", show_fields(got)));
        end else begin
          want = pending_times.pop_front();
          if (got !== want)
            flag_error($sformatf("result %0d\n  expected %s\n  actual   %s", checked_count,
                                 show_fields(want), show_fields(got)));
        end
        checked_count++;
      end
      if (start && !busy) begin
        idle_cycles = 0;
        pending_times.push_back(typed_valid ? typed_want : decode_rtc_snapshot(stim));
      end
      if (cfg_we) begin
        case (cfg_index)
          cctd_pkg::CFG_BINARY_MODE:     mode_binary = cfg_wdata[0];
          cctd_pkg::CFG_HOUR24_MODE:     mode_hour24 = cfg_wdata[0];
          cctd_pkg::CFG_DEFAULT_CENTURY: mode_century = cfg_wdata;
          default: ;
        endcase
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_times.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [7:0] encode_rtc(input int unsigned v);
    return mode_binary ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Mostly legal snapshots in the current modes; some with one byte broken, some pure noise
  function automatic snap_t random_snapshot();
    snap_t       s;
    int unsigned kind, pick;
    s.second = encode_rtc($urandom_range(0, 59));
    s.minute = encode_rtc($urandom_range(0, 59));
    if (mode_hour24) begin
      s.hour = encode_rtc($urandom_range(0, 23));
    end else begin
      s.hour = encode_rtc($urandom_range(1, 12));
      s.hour[7] = 1'($urandom_range(0, 1));
    end
    s.day = encode_rtc($urandom_range(1, 31));
    s.month = encode_rtc($urandom_range(1, 12));
    s.weekday = 8'($urandom_range(1, 7));
    s.year = encode_rtc($urandom_range(0, 99));
    s.century = $urandom_range(0, 1) ? 8'd0 : encode_rtc($urandom_range(1, 99));
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      s = {$urandom, $urandom};
    end else if (kind < 27) begin
      pick = $urandom_range(0, 7);
      s[pick * 8 +: 8] = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  task automatic send_snapshot(input snap_t s, input bit typed, input clock_fields_t want);
    @(negedge clk);
    start <= 1'b1;
    stim <= s;
    typed_valid <= typed;
    typed_want <= want;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a while and scramble the bytes the block should ignore
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      stim <= {$urandom, $urandom};
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_times.size() != 0) @(negedge clk);
  endtask

  task automatic set_modes(input bit binary, input bit hour24, input logic [6:0] century);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= cctd_pkg::CFG_BINARY_MODE;
    cfg_wdata <= {6'd0, binary};
    @(negedge clk);
    cfg_index <= cctd_pkg::CFG_HOUR24_MODE;
    cfg_wdata <= {6'd0, hour24};
    @(negedge clk);
    cfg_index <= cctd_pkg::CFG_DEFAULT_CENTURY;
    cfg_wdata <= century;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin : driver
    directed_row_t row;
    int            sent, burst;
    bit            binary, hour24;
    logic [6:0]    century;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = directed_rows[i];
      if (row.binary != mode_binary || row.hour24 != mode_hour24 ||
          row.century != mode_century)
        set_modes(row.binary, row.hour24, row.century);
      send_snapshot(row.snap, row.typed, row.want);
      hold_off(i % 3);
    end

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      if (p < 4) begin
        binary = FIXED_BINARY[p];
        hour24 = FIXED_HOUR24[p];
        century = FIXED_CENTURY[p];
      end else begin
        binary = 1'($urandom_range(0, 1));
        hour24 = 1'($urandom_range(0, 1));
        century = 7'($urandom_range(0, 127));
      end
      set_modes(binary, hour24, century);
      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < ITEMS_PER_SETTING; k++) begin
          send_snapshot(random_snapshot(), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 15) == 0) wait_drained();
        else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (RESULT_LATENCY + 3) @(posedge clk);
    if (pending_times.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_times.size()));
    $display("summary: %0d snapshots checked under %0d mode settings, %0d flagged out of range",
             checked_count, setting_count, flagged_count);
    $display("summary: %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== cmos_clock_time_decoder.f =====
+incdir+rtl
rtl/cctd_pkg.sv
rtl/cmos_clock_time_decoder.sv
tb/cmos_clock_time_decoder_test.sv
